@@ design/nps_pkg.sv @@
`default_nettype none

package nps_pkg;

    // default number of process slots
    localparam int NUM_PROCESSES_DEF = 8;

    // field widths
    localparam int ARR_W      = 16;
    localparam int BUR_W      = 16;
    localparam int PRI_W      = 8;
    localparam int KEY_W      = 16;
    localparam int TIME_W     = 24;
    localparam int PROC_W     = 3;
    localparam int MODE_W     = 2;
    localparam int CTX_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // sort key selection
    localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CTX_SW = 1'b1;

    // one stored process record
    typedef struct packed {
        logic [ARR_W-1:0] arrival;
        logic [BUR_W-1:0] burst;
        logic [PRI_W-1:0] prio;
    } t_rec;

    localparam int REC_W = ARR_W + BUR_W + PRI_W;

    // sort key of a record; unused mode code falls back to priority
    function automatic logic [KEY_W-1:0] key_of(input logic [MODE_W-1:0] mode,
                                                input t_rec rec);
        logic [KEY_W-1:0] key;
        unique case (mode)
            MODE_FCFS: key = rec.arrival;
            MODE_SJF:  key = rec.burst;
            default:   key = {{(KEY_W-PRI_W){1'b0}}, rec.prio};
        endcase
        return key;
    endfunction

endpackage

`default_nettype wire

@@ design/nps_in_if.sv @@
`default_nettype none

interface nps_in_if;
    logic                     valid;
    logic                     ready;
    logic [nps_pkg::ARR_W-1:0] arrival_time;
    logic [nps_pkg::BUR_W-1:0] burst_time;
    logic [nps_pkg::PRI_W-1:0] priority_level;
    logic                     last_process;

    modport source (
        output valid, arrival_time, burst_time, priority_level, last_process,
        input  ready
    );
    modport sink (
        input  valid, arrival_time, burst_time, priority_level, last_process,
        output ready
    );
endinterface

`default_nettype wire

@@ design/nps_out_if.sv @@
`default_nettype none

interface nps_out_if;
    logic                       valid;
    logic                       ready;
    logic [nps_pkg::PROC_W-1:0] process;
    logic [nps_pkg::TIME_W-1:0] start_time;
    logic [nps_pkg::TIME_W-1:0] finish_time;
    logic [nps_pkg::TIME_W-1:0] waiting_time;
    logic [nps_pkg::TIME_W-1:0] end_time;
    logic                       last_result;

    modport source (
        output valid, process, start_time, finish_time, waiting_time, end_time,
               last_result,
        input  ready
    );
    modport sink (
        input  valid, process, start_time, finish_time, waiting_time, end_time,
               last_result,
        output ready
    );
endinterface

`default_nettype wire

@@ design/nps_ram.sv @@
`default_nettype none

module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/nonpreemptive_process_scheduler.sv @@
// Non-preemptive FCFS / SJF / priority scheduler. Process records are taken
// one per cycle into slots numbered from 0; a record with last_process set,
// or the one that fills the last slot, closes the batch and drops i_req.ready
// until the last result of the schedule has entered the output register.
// Each scheduled process then costs one scan over the n loaded records
// through the single read port of the record RAM plus a resolve step, which
// waits while the output register holds a result that is not taken. The
// clock of the schedule starts at the earliest arrival, an idle gap jumps to
// the next arrival, and ties go to the lower slot. A finished result waits
// in the output register while the next scan runs; after the final result
// the block accepts records again even if that result is still waiting.
// Mode 3 sorts by priority. Configuration must be written only while the
// block is idle; the block itself does not enforce this.

`default_nettype none

module nonpreemptive_process_scheduler #(
    parameter int NUM_PROCESSES = nps_pkg::NUM_PROCESSES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [nps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [nps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    nps_in_if.sink                                i_req,
    nps_out_if.source                             o_res
);

    localparam int IW = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int CW = $clog2(NUM_PROCESSES + 1);
    localparam int TW = nps_pkg::TIME_W;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_RESOLVE
    } t_state;

    t_state                         r_state;
    logic [nps_pkg::MODE_W-1:0]     r_mode;
    logic [nps_pkg::CTX_W-1:0]      r_ctx;
    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  r_n;
    logic [CW-1:0]                  r_picks;
    logic [CW-1:0]                  r_scan_idx;
    logic                           r_rd_vld;
    logic [CW-1:0]                  r_rd_idx;
    logic [NUM_PROCESSES-1:0]       r_done;
    logic [TW-1:0]                  r_clock;
    logic                           r_first;

    // best already-arrived candidate
    logic                           r_f_vld;
    logic [nps_pkg::KEY_W-1:0]      r_f_key;
    logic [IW-1:0]                  r_f_idx;
    logic [nps_pkg::ARR_W-1:0]      r_f_arr;
    logic [nps_pkg::BUR_W-1:0]      r_f_bur;

    // earliest unfinished arrival, best key among those
    logic                           r_g_vld;
    logic [nps_pkg::KEY_W-1:0]      r_g_key;
    logic [IW-1:0]                  r_g_idx;
    logic [nps_pkg::ARR_W-1:0]      r_g_arr;
    logic [nps_pkg::BUR_W-1:0]      r_g_bur;

    // output register
    logic                           r_out_vld;
    logic [nps_pkg::PROC_W-1:0]     r_out_proc;
    logic [TW-1:0]                  r_out_start;
    logic [TW-1:0]                  r_out_finish;
    logic [TW-1:0]                  r_out_wait;
    logic [TW-1:0]                  r_out_end;
    logic                           r_out_last;

    nps_pkg::t_rec                  wr_rec;
    nps_pkg::t_rec                  rd_rec;
    logic [nps_pkg::REC_W-1:0]      ram_rdata;
    logic                           ram_we;
    logic [IW-1:0]                  ram_raddr;

    logic                           in_acc;
    logic                           out_acc;
    logic                           out_free;
    logic                           out_load;
    logic                           closes_batch;
    logic                           scan_issue;
    logic [CW-1:0]                  last_idx;

    logic [nps_pkg::KEY_W-1:0]      rd_key;
    logic [TW-1:0]                  rd_arr_ext;
    logic                           rd_undone;
    logic                           rd_arrived;

    logic                           sel_f;
    logic [IW-1:0]                  sel_idx;
    logic [nps_pkg::ARR_W-1:0]      sel_arr;
    logic [nps_pkg::BUR_W-1:0]      sel_bur;
    logic [TW-1:0]                  sel_start;
    logic [TW-1:0]                  sel_finish;
    logic [TW-1:0]                  sel_wait;
    logic [TW-1:0]                  sel_end;
    logic [IW+nps_pkg::PROC_W-1:0]  sel_idx_ext;
    logic                           sel_last;

    // handshakes
    assign i_req.ready = (r_state == ST_LOAD);
    assign in_acc      = i_req.valid && i_req.ready;
    assign out_acc     = r_out_vld && o_res.ready;
    assign out_free    = !r_out_vld || o_res.ready;
    assign out_load    = (r_state == ST_RESOLVE) && out_free;

    assign o_res.valid        = r_out_vld;
    assign o_res.process      = r_out_proc;
    assign o_res.start_time   = r_out_start;
    assign o_res.finish_time  = r_out_finish;
    assign o_res.waiting_time = r_out_wait;
    assign o_res.end_time     = r_out_end;
    assign o_res.last_result  = r_out_last;

    assign closes_batch = i_req.last_process ||
                          (r_count == CW'(NUM_PROCESSES - 1));

    // record store
    assign wr_rec.arrival = i_req.arrival_time;
    assign wr_rec.burst   = i_req.burst_time;
    assign wr_rec.prio    = i_req.priority_level;
    assign ram_we         = in_acc;
    assign scan_issue     = (r_state == ST_SCAN) && (r_scan_idx < r_n);
    assign ram_raddr      = r_scan_idx[IW-1:0];

    nps_ram #(
        .WIDTH (nps_pkg::REC_W),
        .DEPTH (NUM_PROCESSES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (wr_rec),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // compare unit on the record coming out of the ram
    assign rd_rec     = nps_pkg::t_rec'(ram_rdata);
    assign rd_key     = nps_pkg::key_of(r_mode, rd_rec);
    assign rd_arr_ext = {{(TW-nps_pkg::ARR_W){1'b0}}, rd_rec.arrival};
    assign rd_undone  = !r_done[r_rd_idx[IW-1:0]];
    assign rd_arrived = rd_undone && !r_first && (rd_arr_ext <= r_clock);
    assign last_idx   = r_n - CW'(1);

    // timing of the chosen process
    assign sel_f       = r_f_vld;
    assign sel_idx     = sel_f ? r_f_idx : r_g_idx;
    assign sel_arr     = sel_f ? r_f_arr : r_g_arr;
    assign sel_bur     = sel_f ? r_f_bur : r_g_bur;
    assign sel_start   = sel_f ? r_clock : {{(TW-nps_pkg::ARR_W){1'b0}}, r_g_arr};
    assign sel_finish  = sel_start + {{(TW-nps_pkg::BUR_W){1'b0}}, sel_bur};
    assign sel_wait    = sel_start - {{(TW-nps_pkg::ARR_W){1'b0}}, sel_arr};
    assign sel_end     = sel_finish + {{(TW-nps_pkg::CTX_W){1'b0}}, r_ctx};
    assign sel_idx_ext = {{nps_pkg::PROC_W{1'b0}}, sel_idx};
    assign sel_last    = (r_picks == last_idx);

    // sequencer, trackers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_mode    <= nps_pkg::MODE_FCFS;
            r_ctx     <= '0;
            r_count   <= '0;
            r_n       <= '0;
            r_picks   <= '0;
            r_scan_idx <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_idx  <= '0;
            r_done    <= '0;
            r_clock   <= '0;
            r_first   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_g_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    nps_pkg::REG_MODE:   r_mode <= i_cfg_data[nps_pkg::MODE_W-1:0];
                    nps_pkg::REG_CTX_SW: r_ctx  <= i_cfg_data[nps_pkg::CTX_W-1:0];
                    default: ;
                endcase
            end

            // output register drains unless refilled in the same cycle
            if (out_acc && !out_load) begin
                r_out_vld <= 1'b0;
            end

            // read pipeline follows issued addresses
            r_rd_vld <= scan_issue;
            r_rd_idx <= r_scan_idx;

            unique case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        r_count <= r_count + CW'(1);
                        if (closes_batch) begin
                            r_n        <= r_count + CW'(1);
                            r_picks    <= '0;
                            r_done     <= '0;
                            r_first    <= 1'b1;
                            r_scan_idx <= '0;
                            r_f_vld    <= 1'b0;
                            r_g_vld    <= 1'b0;
                            r_state    <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN: begin
                    if (scan_issue) begin
                        r_scan_idx <= r_scan_idx + CW'(1);
                    end
                    if (r_rd_vld) begin
                        // arrived candidate, smaller key wins, ties keep lower slot
                        if (rd_arrived && (!r_f_vld || rd_key < r_f_key)) begin
                            r_f_vld <= 1'b1;
                            r_f_key <= rd_key;
                            r_f_idx <= r_rd_idx[IW-1:0];
                            r_f_arr <= rd_rec.arrival;
                            r_f_bur <= rd_rec.burst;
                        end
                        // earliest arrival, then smallest key at that arrival
                        if (rd_undone && (!r_g_vld || rd_rec.arrival < r_g_arr ||
                            (rd_rec.arrival == r_g_arr && rd_key < r_g_key))) begin
                            r_g_vld <= 1'b1;
                            r_g_key <= rd_key;
                            r_g_idx <= r_rd_idx[IW-1:0];
                            r_g_arr <= rd_rec.arrival;
                            r_g_bur <= rd_rec.burst;
                        end
                        if (r_rd_idx == last_idx) begin
                            r_state <= ST_RESOLVE;
                        end
                    end
                end

                ST_RESOLVE: begin
                    if (out_free) begin
                        r_out_vld    <= 1'b1;
                        r_out_proc   <= sel_idx_ext[nps_pkg::PROC_W-1:0];
                        r_out_start  <= sel_start;
                        r_out_finish <= sel_finish;
                        r_out_wait   <= sel_wait;
                        r_out_end    <= sel_end;
                        r_out_last   <= sel_last;
                        r_clock      <= sel_end;
                        r_first      <= 1'b0;
                        r_scan_idx   <= '0;
                        r_f_vld      <= 1'b0;
                        r_g_vld      <= 1'b0;
                        if (sel_last) begin
                            r_count <= '0;
                            r_picks <= '0;
                            r_done  <= '0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_done[sel_idx] <= 1'b1;
                            r_picks         <= r_picks + CW'(1);
                            r_state         <= ST_SCAN;
                        end
                    end
                end

                default: r_state <= ST_LOAD;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/nps_checker.sv @@
`default_nettype none

module nps_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       in_last,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic                       out_last,
    input wire logic [nps_pkg::PROC_W-1:0] out_proc,
    input wire logic [nps_pkg::TIME_W-1:0] out_start,
    input wire logic [nps_pkg::TIME_W-1:0] out_end
);

    // a closing record stops intake while the schedule runs
    a_close_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready && in_last) |=> !in_ready)
        else $error("request accepted right after a closing record");

    // intake stays closed while a non-final result is shown
    a_mid_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_last) |-> !in_ready)
        else $error("intake open in the middle of a schedule");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_proc) && $stable(out_start) &&
             $stable(out_end) && $stable(out_last)))
        else $error("stalled result changed");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

endmodule

bind nonpreemptive_process_scheduler nps_checker u_nps_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_req.valid),
    .in_ready  (i_req.ready),
    .in_last   (i_req.last_process),
    .out_valid (o_res.valid),
    .out_ready (o_res.ready),
    .out_last  (o_res.last_result),
    .out_proc  (o_res.process),
    .out_start (o_res.start_time),
    .out_end   (o_res.end_time)
);

`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none

module tb;
    import nps_pkg::*;

    localparam int NPROC        = NUM_PROCESSES_DEF;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // one expected or observed schedule entry
    typedef struct packed {
        logic [PROC_W-1:0] proc_idx;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] waiting_time;
        logic [TIME_W-1:0] end_time;
        logic              last_flag;
    } sched_res_t;

    // schedule predictor and result checker
    class sched_scoreboard;
        logic [MODE_W-1:0] sort_mode;
        logic [CTX_W-1:0]  ctx_sw;
        logic [ARR_W-1:0]  arr_q[NPROC];
        logic [BUR_W-1:0]  bur_q[NPROC];
        logic [PRI_W-1:0]  pri_q[NPROC];
        int                loaded;
        sched_res_t        expected_sched[$];
        int                err_count;
        int                checked;
        int                batches;

        function new();
            sort_mode = MODE_FCFS;
            ctx_sw    = '0;
            loaded    = 0;
            err_count = 0;
            checked   = 0;
            batches   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MODE:   sort_mode = data[MODE_W-1:0];
                REG_CTX_SW: ctx_sw    = data[CTX_W-1:0];
                default: ;
            endcase
        endfunction

        // unused mode code sorts by priority
        function logic [KEY_W-1:0] sort_key(int i);
            case (sort_mode)
                MODE_FCFS: return KEY_W'(arr_q[i]);
                MODE_SJF:  return KEY_W'(bur_q[i]);
                default:   return KEY_W'(pri_q[i]);
            endcase
        endfunction

        // store a record; a closing record produces the whole schedule
        function void note_record(logic [ARR_W-1:0] a, logic [BUR_W-1:0] b,
                                  logic [PRI_W-1:0] p, logic last);
            int               n;
            int               best;
            bit               found;
            bit               any;
            logic [NPROC-1:0] done;
            logic [ARR_W-1:0] soonest;
            logic [TIME_W-1:0] clk_v;
            sched_res_t       r;
            if (loaded >= NPROC) loaded = 0;
            arr_q[loaded] = a;
            bur_q[loaded] = b;
            pri_q[loaded] = p;
            loaded++;
            if (!last && loaded < NPROC) return;

            n = loaded;
            done = '0;
            batches++;
            clk_v = TIME_W'(arr_q[0]);
            for (int i = 1; i < n; i++)
                if (arr_q[i] < clk_v) clk_v = TIME_W'(arr_q[i]);

            for (int k = 0; k < n; k++) begin
                found = 1'b0;
                best  = 0;
                for (int pass = 0; pass < 2 && !found; pass++) begin
                    // idle gap: jump to the next unfinished arrival
                    if (pass == 1) begin
                        any = 1'b0;
                        for (int i = 0; i < n; i++) begin
                            if (!done[i] && (!any || arr_q[i] < soonest)) begin
                                soonest = arr_q[i];
                                any = 1'b1;
                            end
                        end
                        clk_v = TIME_W'(soonest);
                    end
                    for (int i = 0; i < n; i++) begin
                        if (!done[i] && arr_q[i] <= clk_v &&
                            (!found || sort_key(i) < sort_key(best))) begin
                            best  = i;
                            found = 1'b1;
                        end
                    end
                end
                r.proc_idx     = best[PROC_W-1:0];
                r.start_time   = clk_v;
                r.finish_time  = clk_v + bur_q[best];
                r.waiting_time = clk_v - arr_q[best];
                r.end_time     = r.finish_time + ctx_sw;
                r.last_flag    = (k == n - 1);
                done[best]     = 1'b1;
                clk_v          = r.end_time;
                expected_sched = {expected_sched, r};
            end
            loaded = 0;
        endfunction

        function void compare_field(string field, logic [TIME_W-1:0] want,
                                    logic [TIME_W-1:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                err_count++;
            end
        endfunction

        function void check_result(sched_res_t got);
            sched_res_t want;
            if (expected_sched.size() == 0) begin
                $error("unexpected result: process %0d start %0d", got.proc_idx,
                       got.start_time);
                err_count++;
                return;
            end
            want = expected_sched.pop_front();
            checked++;
            compare_field("process", want.proc_idx, got.proc_idx);
            compare_field("start_time", want.start_time, got.start_time);
            compare_field("finish_time", want.finish_time, got.finish_time);
            compare_field("waiting_time", want.waiting_time, got.waiting_time);
            compare_field("end_time", want.end_time, got.end_time);
            compare_field("last_result", want.last_flag, got.last_flag);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    nps_in_if  req_if ();
    nps_out_if res_if ();

    nonpreemptive_process_scheduler u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    sched_scoreboard sb;
    int              send_idle  = 0;
    int              recv_stall = 0;
    int              hold_asks  = 0;
    int              records_sent = 0;
    logic [3:0]      modes_seen = '0;
    sched_res_t      seen_res;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // safety net on a hung run
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result receiver: random stalls plus long holds on request
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                res_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= recv_stall);
            end
        end
    end

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen_res.proc_idx     = res_if.process;
            seen_res.start_time   = res_if.start_time;
            seen_res.finish_time  = res_if.finish_time;
            seen_res.waiting_time = res_if.waiting_time;
            seen_res.end_time     = res_if.end_time;
            seen_res.last_flag    = res_if.last_result;
            sb.check_result(seen_res);
        end
    end

    // offer one process record and wait for its acceptance
    task automatic send_record(input logic [ARR_W-1:0] a, input logic [BUR_W-1:0] b,
                               input logic [PRI_W-1:0] p, input logic last);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.arrival_time   <= a;
        req_if.burst_time     <= b;
        req_if.priority_level <= p;
        req_if.last_process   <= last;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_record(a, b, p, last);
        records_sent++;
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // stop requests and wait until every scheduled result has drained
    task automatic settle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (sb.expected_sched.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [MODE_W-1:0] m, input logic [CTX_W-1:0] c);
        settle();
        set_reg(REG_MODE, CFG_DATA_W'(m));
        set_reg(REG_CTX_SW, CFG_DATA_W'(c));
        modes_seen[m] = 1'b1;
    endtask

    task automatic configure_random();
        logic [CTX_W-1:0] c;
        case ($urandom_range(0, 3))
            0:       c = '0;
            1:       c = '1;
            default: c = CTX_W'($urandom_range(0, 255));
        endcase
        configure(MODE_W'($urandom_range(0, 3)), c);
    endtask

    // one batch of random records; a full batch may close without the flag
    task automatic send_batch(input int n, input bit close_by_flag);
        int               sa;
        int               sbst;
        int               sp;
        logic [ARR_W-1:0] a;
        logic [BUR_W-1:0] b;
        logic [PRI_W-1:0] p;
        int               base;
        sa   = $urandom_range(0, 3);
        sbst = $urandom_range(0, 2);
        sp   = $urandom_range(0, 2);
        base = $urandom_range(0, 20000);
        for (int i = 0; i < n; i++) begin
            case (sa)
                0: a = ARR_W'($urandom_range(0, 15));
                1: a = ARR_W'($urandom);
                2: begin
                    base = base + $urandom_range(0, 6000);
                    a = (base > 65535) ? 16'hFFFF : ARR_W'(base);
                end
                default: a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            endcase
            case (sbst)
                0:       b = BUR_W'($urandom_range(0, 20));
                1:       b = BUR_W'($urandom);
                default: b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            endcase
            case (sp)
                0:       p = PRI_W'($urandom_range(0, 3));
                1:       p = PRI_W'($urandom);
                default: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
            send_record(a, b, p, close_by_flag && (i == n - 1));
        end
    endtask

    // stimulus
    initial begin
        int ph_start;
        int n;
        sb = new();
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        req_if.valid          = 1'b0;
        req_if.arrival_time   = '0;
        req_if.burst_time     = '0;
        req_if.priority_level = '0;
        req_if.last_process   = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single-record batches at the field extremes
        configure(MODE_FCFS, 8'd0);
        send_record(16'h0000, 16'h0000, 8'h00, 1'b1);
        send_record(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        // equal arrivals tie to the lower slot, then an idle gap
        send_record(16'd100, 16'd5, 8'd3, 1'b0);
        send_record(16'd100, 16'd5, 8'd3, 1'b0);
        send_record(16'd5000, 16'd1, 8'd0, 1'b1);

        // full batch closes without the last flag
        configure(MODE_SJF, 8'hFF);
        for (int i = 0; i < NPROC; i++)
            send_record(ARR_W'(i * 3), BUR_W'(((i * 37) % 8) * 1000), PRI_W'(i), 1'b0);

        // priority ties and a late arrival
        configure(MODE_PRIO, 8'd17);
        send_record(16'd0, 16'd10, 8'd255, 1'b0);
        send_record(16'd1, 16'd20, 8'd0, 1'b0);
        send_record(16'hFFFF, 16'd30, 8'd0, 1'b0);
        send_record(16'd2, 16'd0, 8'd128, 1'b1);

        // unused mode code, full batch closed by the flag
        configure(MODE_UNUSED, 8'd0);
        for (int i = 0; i < NPROC; i++)
            send_record(16'd7, BUR_W'(i * 100), PRI_W'(i % 2), i == NPROC - 1);

        // random batches under four idle mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 49; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 49; end
                default: begin send_idle = 22; recv_stall = 22; end
            endcase
            configure_random();
            if (ph == 3) hold_asks++;
            ph_start = records_sent;
            while (records_sent - ph_start < 100) begin
                n = $urandom_range(1, NPROC);
                send_batch(n, (n < NPROC) || ($urandom_range(0, 1) == 1));
                if ($urandom_range(0, 4) == 0) configure_random();
            end
        end

        // drain and report
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (sb.expected_sched.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Scheduled %0d batches from %0d records, %0d results checked",
                 sb.batches, records_sent, sb.checked);
        $display("Mode codes used %b, four idle/stall mixes and one long output hold",
                 modes_seen);
        if (sb.err_count == 0 && sb.expected_sched.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
